// ===== hdl/ehist_pkg.sv =====
// shared types and constants of the equal-width histogram
`timescale 1ns / 1ps
`default_nettype none
package ehist_pkg;
   localparam int BIN_SLOTS_DEFAULT   = 256;
   localparam int COUNT_WIDTH_DEFAULT = 32;

   localparam int CSR_INDEX_W = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_LOW  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_HIGH = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIN_WIDTH  = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIN_COUNT  = 8'd3;

   localparam logic [31:0] RANGE_LOW_RESET  = 32'd0;
   localparam logic [31:0] RANGE_HIGH_RESET = 32'd6553600;
   localparam logic [30:0] BIN_WIDTH_RESET  = 31'd655360;
   localparam logic [8:0]  BIN_COUNT_RESET  = 9'd10;

   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_ADD    = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [1:0] CMD_NONE  = 2'd0;
   localparam logic [1:0] CMD_CLEAR = 2'd1;
   localparam logic [1:0] CMD_ADD   = 2'd2;
   localparam logic [1:0] CMD_READ  = 2'd3;

   typedef struct packed {
      logic [1:0] kind;
      logic       zero;   // read beyond the store returns zero
      logic [7:0] bin;
   } cmd_type;

   typedef struct packed {
      logic [31:0] range_low;
      logic [31:0] range_high;
      logic [30:0] bin_width;
      logic [8:0]  bin_count;
   } csr_type;
endpackage
`default_nettype wire

// ===== hdl/ehist_if.sv =====
// handshake channels of the histogram: request, response and register write
`timescale 1ns / 1ps
`default_nettype none
interface ehist_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [31:0] sample;
   logic [7:0]  bin_select;
   modport source (output valid, op, sample, bin_select, input ready);
   modport sink   (input valid, op, sample, bin_select, output ready);
endinterface

interface ehist_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  bin;
   logic [31:0] count;
   logic        in_range;
   modport source (output valid, bin, count, in_range, input ready);
   modport sink   (input valid, bin, count, in_range, output ready);
endinterface

interface ehist_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/ehist_front.sv =====
// front end: range check and bin index by a one-bit-per-cycle divider
`timescale 1ns / 1ps
`default_nettype none
module ehist_front #(
   parameter int BIN_SLOTS = ehist_pkg::BIN_SLOTS_DEFAULT,
   parameter int IW        = $clog2(BIN_SLOTS)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              init_done,
   input  wire ehist_pkg::csr_type csr,
   ehist_req_if.sink              req,
   output ehist_pkg::cmd_type     cmd,
   output logic [IW-1:0]          cmd_idx,
   output logic                   cmd_push,
   input  wire logic              cmd_full
);
   import ehist_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_DIV   = 2'd1;
   localparam logic [1:0] ST_CLAMP = 2'd2;
   localparam logic [1:0] ST_PUSH  = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [4:0]    step_ff, step_in;
   logic [31:0]   quo_ff, quo_in;
   logic [30:0]   rem_ff, rem_in;
   cmd_type       cmd_ff, cmd_in;
   logic [IW-1:0] idx_ff, idx_in;

   logic          accept;
   logic          in_rng;
   logic [32:0]   diff;
   logic [30:0]   divisor;
   logic [31:0]   trial;
   logic [31:0]   bins_used;
   logic [31:0]   last_bin;
   logic [31:0]   clamped;
   logic [IW+7:0] sel_ext;
   logic [IW+7:0] clamp_ext;

   assign req.ready = init_done && (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;

   assign in_rng  = ($signed(req.sample) >= $signed(csr.range_low)) &&
                    ($signed(req.sample) <  $signed(csr.range_high));
   assign diff    = {req.sample[31], req.sample} - {csr.range_low[31], csr.range_low};
   assign divisor = (csr.bin_width == '0) ? 31'd1 : csr.bin_width;
   assign trial   = {rem_ff, quo_ff[31]};

   always_comb begin
      bins_used = {23'd0, csr.bin_count};
      if (bins_used == 32'd0) begin
         bins_used = 32'd1;
      end
      if (bins_used > 32'(BIN_SLOTS)) begin
         bins_used = 32'(BIN_SLOTS);
      end
   end
   assign last_bin  = bins_used - 32'd1;
   assign clamped   = (quo_ff > last_bin) ? last_bin : quo_ff;
   assign sel_ext   = {{IW{1'b0}}, req.bin_select};
   assign clamp_ext = {8'd0, clamped[IW-1:0]};

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      cmd_in   = cmd_ff;
      idx_in   = idx_ff;
      cmd_push = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in.kind = CMD_NONE;
               cmd_in.zero = 1'b0;
               cmd_in.bin  = 8'd0;
               idx_in      = '0;
               state_in    = ST_PUSH;
               case (req.op)
                  OP_CLEAR: cmd_in.kind = CMD_CLEAR;
                  OP_ADD: begin
                     if (in_rng) begin
                        quo_in   = diff[31:0];
                        rem_in   = '0;
                        step_in  = '0;
                        state_in = ST_DIV;
                     end
                  end
                  OP_READ: begin
                     cmd_in.kind = CMD_READ;
                     cmd_in.bin  = req.bin_select;
                     cmd_in.zero = !({24'd0, req.bin_select} < 32'(BIN_SLOTS));
                     idx_in      = sel_ext[IW-1:0];
                  end
                  default: cmd_in.kind = CMD_NONE;
               endcase
            end
         end
         ST_DIV: begin
            if (trial >= {1'b0, divisor}) begin
               rem_in = 31'(trial - {1'b0, divisor});
               quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               rem_in = trial[30:0];
               quo_in = {quo_ff[30:0], 1'b0};
            end
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd31) begin
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            cmd_in.kind = CMD_ADD;
            cmd_in.zero = 1'b0;
            cmd_in.bin  = clamp_ext[7:0];
            idx_in      = clamped[IW-1:0];
            state_in    = ST_PUSH;
         end
         ST_PUSH: begin
            if (!cmd_full) begin
               cmd_push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      cmd_ff  <= cmd_in;
      idx_ff  <= idx_in;
   end

   assign cmd     = cmd_ff;
   assign cmd_idx = idx_ff;
endmodule
`default_nettype wire

// ===== hdl/ehist_queue.sv =====
// two-entry command queue between front and back
`timescale 1ns / 1ps
`default_nettype none
module ehist_queue #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  not_empty
);
   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ff, wr_in;
   logic             rd_ff, rd_in;
   logic [1:0]       fill_ff, fill_in;

   assign full      = (fill_ff == 2'd2);
   assign not_empty = (fill_ff != 2'd0);
   assign pop_data  = slot_ff[rd_ff];

   always_comb begin
      wr_in   = push ? !wr_ff : wr_ff;
      rd_in   = pop ? !rd_ff : rd_ff;
      fill_in = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= 1'b0;
         rd_ff   <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end
endmodule
`default_nettype wire

// ===== hdl/ehist_back.sv =====
// back end: bin memory with clearing sweep, read-modify-write and response register
`timescale 1ns / 1ps
`default_nettype none
module ehist_back #(
   parameter int BIN_SLOTS   = ehist_pkg::BIN_SLOTS_DEFAULT,
   parameter int COUNT_WIDTH = ehist_pkg::COUNT_WIDTH_DEFAULT,
   parameter int IW          = $clog2(BIN_SLOTS)
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ehist_pkg::cmd_type cmd,
   input  wire logic [IW-1:0]      cmd_idx,
   input  wire logic               cmd_avail,
   output logic                    cmd_pop,
   output logic                    init_done,
   ehist_rsp_if.source             rsp
);
   import ehist_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SWEEP = 2'd1;
   localparam logic [1:0] ST_RMW   = 2'd2;
   localparam logic [1:0] ST_RDOUT = 2'd3;
   localparam logic [IW-1:0] LAST_ENTRY = IW'(BIN_SLOTS - 1);

   logic [COUNT_WIDTH-1:0] mem [BIN_SLOTS];
   logic [COUNT_WIDTH-1:0] rd_data_ff;

   logic [1:0]    state_ff, state_in;
   logic [IW-1:0] ptr_ff, ptr_in;
   logic          init_ff, init_in;
   logic          clr_rsp_ff, clr_rsp_in;
   logic [7:0]    bin_ff, bin_in;
   logic [IW-1:0] addr_ff, addr_in;

   logic                   out_valid_ff, out_valid_in;
   logic [7:0]             out_bin_ff, out_bin_in;
   logic [31:0]            out_count_ff, out_count_in;
   logic                   out_in_range_ff, out_in_range_in;

   logic                   wr_en;
   logic [IW-1:0]          wr_addr;
   logic [COUNT_WIDTH-1:0] wr_data;
   logic [IW-1:0]          rd_addr;
   logic [COUNT_WIDTH-1:0] bumped;
   logic [COUNT_WIDTH+31:0] bumped_ext;
   logic [COUNT_WIDTH+31:0] rd_ext;

   assign bumped     = (rd_data_ff == '1) ? rd_data_ff : rd_data_ff + COUNT_WIDTH'(1);
   assign bumped_ext = {32'd0, bumped};
   assign rd_ext     = {32'd0, rd_data_ff};
   assign cmd_pop    = (state_ff == ST_IDLE) && cmd_avail && !out_valid_ff;
   assign init_done  = init_ff;

   always_comb begin
      state_in        = state_ff;
      ptr_in          = ptr_ff;
      init_in         = init_ff;
      clr_rsp_in      = clr_rsp_ff;
      bin_in          = bin_ff;
      addr_in         = addr_ff;
      out_valid_in    = out_valid_ff && !rsp.ready;
      out_bin_in      = out_bin_ff;
      out_count_in    = out_count_ff;
      out_in_range_in = out_in_range_ff;
      wr_en           = 1'b0;
      wr_addr         = addr_ff;
      wr_data         = bumped;
      rd_addr         = cmd_idx;
      case (state_ff)
         ST_SWEEP: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff;
            wr_data = '0;
            ptr_in  = ptr_ff + IW'(1);
            if (ptr_ff == LAST_ENTRY) begin
               state_in = ST_IDLE;
               init_in  = 1'b1;
               if (clr_rsp_ff) begin
                  out_valid_in    = 1'b1;
                  out_bin_in      = 8'd0;
                  out_count_in    = 32'd0;
                  out_in_range_in = 1'b0;
               end
            end
         end
         ST_IDLE: begin
            if (cmd_pop) begin
               bin_in  = cmd.bin;
               addr_in = cmd_idx;
               case (cmd.kind)
                  CMD_CLEAR: begin
                     ptr_in     = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = ST_SWEEP;
                  end
                  CMD_ADD: state_in = ST_RMW;
                  CMD_READ: begin
                     if (cmd.zero) begin
                        out_valid_in    = 1'b1;
                        out_bin_in      = cmd.bin;
                        out_count_in    = 32'd0;
                        out_in_range_in = 1'b0;
                     end else begin
                        state_in = ST_RDOUT;
                     end
                  end
                  default: begin
                     out_valid_in    = 1'b1;
                     out_bin_in      = 8'd0;
                     out_count_in    = 32'd0;
                     out_in_range_in = 1'b0;
                  end
               endcase
            end
         end
         ST_RMW: begin
            wr_en           = 1'b1;
            out_valid_in    = 1'b1;
            out_bin_in      = bin_ff;
            out_count_in    = bumped_ext[31:0];
            out_in_range_in = 1'b1;
            state_in        = ST_IDLE;
         end
         ST_RDOUT: begin
            out_valid_in    = 1'b1;
            out_bin_in      = bin_ff;
            out_count_in    = rd_ext[31:0];
            out_in_range_in = 1'b0;
            state_in        = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         ptr_ff       <= '0;
         init_ff      <= 1'b0;
         clr_rsp_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         init_ff      <= init_in;
         clr_rsp_ff   <= clr_rsp_in;
         out_valid_ff <= out_valid_in;
      end
      bin_ff          <= bin_in;
      addr_ff         <= addr_in;
      out_bin_ff      <= out_bin_in;
      out_count_ff    <= out_count_in;
      out_in_range_ff <= out_in_range_in;
   end

   assign rsp.valid    = out_valid_ff;
   assign rsp.bin      = out_bin_ff;
   assign rsp.count    = out_count_ff;
   assign rsp.in_range = out_in_range_ff;
endmodule
`default_nettype wire

// ===== hdl/equal_width_histogram_top.sv =====
// top level of the equal-width histogram
`timescale 1ns / 1ps
`default_nettype none
// Equal-width histogram over signed Q16.16 samples. After reset the bin memory is
// swept to zero, one entry per cycle, while no request is taken; register writes
// are taken at any time. One request is in the front at a time: an in-range add
// holds the front through the 32-step divider that finds the bin, a clamp step and
// a hand-over step that waits while the queue is full, and its response is
// registered after the memory read-modify-write; a read, an unused op or an
// out-of-range sample goes straight to the hand-over step, and a read of a stored
// bin is answered after its memory read; a clear responds when its sweep ends. The
// front and the memory side run apart through a two-entry queue, so the next
// request is taken while a response still waits to be collected.
module equal_width_histogram_top #(
   parameter int BIN_SLOTS   = ehist_pkg::BIN_SLOTS_DEFAULT,
   parameter int COUNT_WIDTH = ehist_pkg::COUNT_WIDTH_DEFAULT
) (
   input wire logic    clock,
   input wire logic    reset,
   ehist_req_if.sink   req_bus,
   ehist_rsp_if.source rsp_bus,
   ehist_csr_if.sink   csr_bus
);
   import ehist_pkg::*;

   localparam int IW = $clog2(BIN_SLOTS);
   localparam int QW = $bits(cmd_type) + IW;

   csr_type       csr_ff, csr_in;
   cmd_type       f_cmd, b_cmd;
   logic [IW-1:0] f_idx, b_idx;
   logic          push, full, pop, avail, init_done;
   logic [QW-1:0] q_out;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      csr_in = csr_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_RANGE_LOW:  csr_in.range_low  = csr_bus.data;
            CSR_RANGE_HIGH: csr_in.range_high = csr_bus.data;
            CSR_BIN_WIDTH:  csr_in.bin_width  = csr_bus.data[30:0];
            CSR_BIN_COUNT:  csr_in.bin_count  = csr_bus.data[8:0];
            default:        csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.range_low  <= RANGE_LOW_RESET;
         csr_ff.range_high <= RANGE_HIGH_RESET;
         csr_ff.bin_width  <= BIN_WIDTH_RESET;
         csr_ff.bin_count  <= BIN_COUNT_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   ehist_front #(.BIN_SLOTS(BIN_SLOTS), .IW(IW)) u_front (
      .clock, .reset, .init_done, .csr(csr_ff), .req(req_bus),
      .cmd(f_cmd), .cmd_idx(f_idx), .cmd_push(push), .cmd_full(full)
   );

   ehist_queue #(.WIDTH(QW)) u_queue (
      .clock, .reset, .push, .push_data({f_cmd, f_idx}), .full,
      .pop, .pop_data(q_out), .not_empty(avail)
   );

   assign b_cmd = q_out[QW-1:IW];
   assign b_idx = q_out[IW-1:0];

   ehist_back #(.BIN_SLOTS(BIN_SLOTS), .COUNT_WIDTH(COUNT_WIDTH), .IW(IW)) u_back (
      .clock, .reset, .cmd(b_cmd), .cmd_idx(b_idx), .cmd_avail(avail),
      .cmd_pop(pop), .init_done, .rsp(rsp_bus)
   );

   // a counted sample always leaves a nonzero count behind
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.in_range |-> rsp_bus.count != 32'd0)
      else $error("counted sample with zero count");

   a_no_req_in_sweep: assert property (@(posedge clock) disable iff (reset)
      !init_done |-> !req_bus.ready)
      else $error("request taken during clearing sweep");

   a_queue_safe: assert property (@(posedge clock) disable iff (reset)
      (push |-> !full) and (pop |-> avail))
      else $error("command queue overflow or underflow");
endmodule
`default_nettype wire
